// ----- rtl/jos_pkg.sv -----
// Shared types and constants for the Josephus elimination-order block.
// Used by every module under rtl/; depends on nothing else.

package jos_pkg;

  localparam int unsigned MaxPeople = 64;
  localparam int unsigned PersonW   = 7;
  localparam int unsigned CountW    = 7;
  localparam int unsigned KindW     = 2;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned DivStepW  = $clog2(CountW);

  typedef enum logic [KindW-1:0] {
    KIND_ELIM = 2'd0,
    KIND_SURV = 2'd1,
    KIND_ERR  = 2'd2,
    KIND_RST  = 2'd3
  } kind_e;

  localparam logic [CfgIdxW-1:0] CFG_PEOPLE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_STEP   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_OFFSET = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_MOD,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [PersonW-1:0] person;
    kind_e              kind;
  } result_t;

endpackage

// ----- rtl/josephus_elimination_order.sv -----
// Top level of the Josephus elimination-order block: config registers,
// output register and assertions. Depends on jos_pkg, jos_ctrl,
// jos_alive_mem and jos_mod_unit.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+----------------------------------
//   cfg      | cfg_wr_en_i             | cfg_index_i, cfg_data_i
//   in       | in_valid_i / in_stall_o | restart_i
//   out      | out_valid_o/out_stall_i | person_o, kind_o
//
// Flow: an error request or a survivor step goes from idle straight to done. A
// valid restart sweeps every ring slot in the fill state. An elimination runs
// the modulo unit, then walks the ring slot by slot through the registered read.
// Reset clears the game, the sequencer and the output register; the alive
// memory needs no clearing pass since a restart rewrites all of it.
// A stalled output holds its result; the next request is taken meanwhile,
// and its result waits in the sequencer until the output register drains.

module josephus_elimination_order #(
  parameter int unsigned MaxPeople = jos_pkg::MaxPeople
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_wr_en_i,
  input  logic [jos_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [jos_pkg::CountW-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        restart_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [jos_pkg::PersonW-1:0] person_o,
  output logic [jos_pkg::KindW-1:0]   kind_o
);

  localparam int unsigned AddrW = $clog2(MaxPeople);
  localparam int unsigned CW    = jos_pkg::CountW;

  logic [CW-1:0] people_q, step_q, offset_q;

  logic             out_valid_q;
  jos_pkg::result_t out_res_q;

  logic             res_valid;
  jos_pkg::result_t res;
  logic             res_take;

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic             mem_wdata;
  logic             mem_re;
  logic [AddrW-1:0] mem_raddr;
  logic             mem_rdata;

  logic          mod_start;
  logic [CW-1:0] mod_dividend;
  logic [CW-1:0] mod_divisor;
  logic          mod_done;
  logic [CW-1:0] mod_rem;

  // configuration registers; writes to an unused index are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      people_q <= CW'(8);
      step_q   <= CW'(2);
      offset_q <= '0;
    end else if (cfg_wr_en_i) begin
      case (cfg_index_i)
        jos_pkg::CFG_PEOPLE: people_q <= cfg_data_i;
        jos_pkg::CFG_STEP:   step_q   <= cfg_data_i;
        jos_pkg::CFG_OFFSET: offset_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // load the output register whenever it is empty or draining this cycle
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign person_o    = out_res_q.person;
  assign kind_o      = out_res_q.kind;

  jos_ctrl #(
    .MaxPeople (MaxPeople),
    .AddrW     (AddrW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .restart_i      (restart_i),
    .people_i       (people_q),
    .step_i         (step_q),
    .offset_i       (offset_q),
    .res_valid_o    (res_valid),
    .res_o          (res),
    .res_take_i     (res_take),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_re_o       (mem_re),
    .mem_raddr_o    (mem_raddr),
    .mem_rdata_i    (mem_rdata),
    .mod_start_o    (mod_start),
    .mod_dividend_o (mod_dividend),
    .mod_divisor_o  (mod_divisor),
    .mod_done_i     (mod_done),
    .mod_rem_i      (mod_rem)
  );

  jos_alive_mem #(
    .MaxPeople (MaxPeople),
    .AddrW     (AddrW)
  ) u_alive_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  jos_mod_unit u_mod_unit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (mod_dividend),
    .divisor_i  (mod_divisor),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // an accepted request always leaves the sequencer busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted but sequencer not busy");

  // a result the output register cannot take is held unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_take |=> res_valid && $stable(res))
    else $error("pending result lost or changed");

  // an elimination always names a person
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == jos_pkg::KIND_ELIM) |-> person_o != '0)
    else $error("elimination without a person number");

  // a restart result never names a person
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == jos_pkg::KIND_RST) |-> person_o == '0)
    else $error("restart result with a person number");

endmodule

// ----- rtl/jos_alive_mem.sv -----
// Alive-mark memory: one bit per ring slot, one write and one read port.
// Read data is registered. Uses jos_pkg for defaults.

module jos_alive_mem #(
  parameter int unsigned MaxPeople = jos_pkg::MaxPeople,
  parameter int unsigned AddrW     = $clog2(MaxPeople)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic             wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic             rdata_o
);

  logic mem_q [MaxPeople];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/jos_mod_unit.sv -----
// Iterative remainder unit: one restoring-division bit per cycle.
// Uses jos_pkg for operand widths.

module jos_mod_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [jos_pkg::CountW-1:0] dividend_i,
  input  logic [jos_pkg::CountW-1:0] divisor_i,
  output logic                       done_o,
  output logic [jos_pkg::CountW-1:0] rem_o
);

  localparam int unsigned W = jos_pkg::CountW;

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [jos_pkg::DivStepW-1:0] cnt_q, cnt_d;
  logic [W-1:0]                 a_q, a_d;
  logic [W-1:0]                 r_q, r_d;
  logic [W:0]                   r_sh;
  logic [W:0]                   r_sub;

  assign r_sh  = {r_q, a_q[W-1]};
  assign r_sub = r_sh - {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    r_d    = r_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = jos_pkg::DivStepW'(W - 1);
      a_d    = dividend_i;
      r_d    = '0;
    end else if (busy_q) begin
      a_d = {a_q[W-2:0], 1'b0};
      // keep the shifted partial remainder or subtract the divisor
      r_d = (r_sh >= {1'b0, divisor_i}) ? r_sub[W-1:0] : r_sh[W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    a_q   <= a_d;
    r_q   <= r_d;
  end

  assign done_o = done_q;
  assign rem_o  = r_q;

endmodule

// ----- rtl/jos_ctrl.sv -----
// Sequencer: fills the ring, drives the modulo unit and walks the alive marks.
// Depends on jos_pkg; talks to jos_alive_mem and jos_mod_unit.

module jos_ctrl #(
  parameter int unsigned MaxPeople = jos_pkg::MaxPeople,
  parameter int unsigned AddrW     = $clog2(MaxPeople)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        restart_i,
  input  logic [jos_pkg::CountW-1:0]  people_i,
  input  logic [jos_pkg::CountW-1:0]  step_i,
  input  logic [jos_pkg::CountW-1:0]  offset_i,
  output logic                        res_valid_o,
  output jos_pkg::result_t            res_o,
  input  logic                        res_take_i,
  output logic                        mem_we_o,
  output logic [AddrW-1:0]            mem_waddr_o,
  output logic                        mem_wdata_o,
  output logic                        mem_re_o,
  output logic [AddrW-1:0]            mem_raddr_o,
  input  logic                        mem_rdata_i,
  output logic                        mod_start_o,
  output logic [jos_pkg::CountW-1:0]  mod_dividend_o,
  output logic [jos_pkg::CountW-1:0]  mod_divisor_o,
  input  logic                        mod_done_i,
  input  logic [jos_pkg::CountW-1:0]  mod_rem_i
);

  localparam int unsigned CW = jos_pkg::CountW;
  localparam int unsigned PW = jos_pkg::PersonW;
  localparam logic [CW-1:0]    PeopleMax = CW'(MaxPeople);
  localparam logic [CW-1:0]    MinStep   = CW'(2);
  localparam logic [CW-1:0]    One       = CW'(1);
  localparam logic [AddrW-1:0] LastSlot  = AddrW'(MaxPeople - 1);

  jos_pkg::state_e  state_q, state_d;
  logic             active_q, active_d;
  logic [CW-1:0]    remaining_q, remaining_d;
  logic [AddrW-1:0] pointer_q, pointer_d;
  logic             rd_vld_q, rd_vld_d;
  logic [AddrW-1:0] fill_q, fill_d;
  logic [CW-1:0]    adv_q, adv_d;
  logic [CW-1:0]    hits_q, hits_d;
  logic [AddrW-1:0] cur_q, cur_d;
  logic [AddrW-1:0] scan_q, scan_d;
  logic [AddrW-1:0] slot_q, slot_d;
  jos_pkg::result_t res_q, res_d;

  logic          accept;
  logic          bad_restart;
  logic          step_err;
  logic          is_last;
  logic          k_low;
  logic          hit;
  logic [CW-1:0] hit_n;
  logic [CW-1:0] adv_inc;
  logic          fill_last;

  function automatic logic [AddrW-1:0] ring_next(input logic [AddrW-1:0] x);
    ring_next = (x == LastSlot) ? '0 : x + 1'b1;
  endfunction

  function automatic logic [PW-1:0] to_person(input logic [AddrW-1:0] x);
    to_person = PW'(x) + PW'(1);
  endfunction

  assign accept      = in_valid_i && (state_q == jos_pkg::ST_IDLE);
  assign bad_restart = !(people_i inside {[One:PeopleMax]}) || (offset_i > people_i);
  assign step_err    = !active_q || (remaining_q == '0);
  assign is_last     = (remaining_q == One);
  assign k_low       = (step_i < MinStep);
  assign hit         = rd_vld_q && mem_rdata_i;
  assign hit_n       = hits_q + One;
  assign adv_inc     = adv_q + One;
  assign fill_last   = (fill_q == LastSlot);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      jos_pkg::ST_IDLE: begin
        if (accept) begin
          if (restart_i) begin
            state_d = bad_restart ? jos_pkg::ST_DONE : jos_pkg::ST_FILL;
          end else if (step_err || is_last || k_low) begin
            state_d = jos_pkg::ST_DONE;
          end else begin
            state_d = jos_pkg::ST_MOD;
          end
        end
      end
      jos_pkg::ST_FILL: begin
        if (fill_last) state_d = jos_pkg::ST_DONE;
      end
      jos_pkg::ST_MOD: begin
        if (mod_done_i) state_d = jos_pkg::ST_SCAN;
      end
      jos_pkg::ST_SCAN: begin
        if (hit && (hit_n == adv_inc)) state_d = jos_pkg::ST_DONE;
      end
      jos_pkg::ST_DONE: begin
        if (res_take_i) state_d = jos_pkg::ST_IDLE;
      end
      default: state_d = jos_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory strobes
  always_comb begin
    active_d    = active_q;
    remaining_d = remaining_q;
    pointer_d   = pointer_q;
    rd_vld_d    = 1'b0;
    fill_d      = fill_q;
    adv_d       = adv_q;
    hits_d      = hits_q;
    cur_d       = cur_q;
    scan_d      = scan_q;
    slot_d      = slot_q;
    res_d       = res_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = pointer_q;
    mem_wdata_o = 1'b0;
    mem_re_o    = 1'b0;
    mem_raddr_o = scan_q;
    mod_start_o = 1'b0;
    case (state_q)
      jos_pkg::ST_IDLE: begin
        if (accept) begin
          if (restart_i) begin
            active_d    = 1'b0;
            remaining_d = '0;
            pointer_d   = '0;
            res_d       = '{person: '0, kind: jos_pkg::KIND_ERR};
            if (!bad_restart) begin
              active_d    = 1'b1;
              remaining_d = people_i;
              pointer_d   = (offset_i == people_i) ? '0 : offset_i[AddrW-1:0];
              fill_d      = '0;
              res_d       = '{person: '0, kind: jos_pkg::KIND_RST};
            end
          end else if (step_err) begin
            res_d = '{person: '0, kind: jos_pkg::KIND_ERR};
          end else if (is_last) begin
            // drop the survivor and end the game
            active_d    = 1'b0;
            remaining_d = '0;
            mem_we_o    = 1'b1;
            mem_waddr_o = pointer_q;
            res_d       = '{person: to_person(pointer_q), kind: jos_pkg::KIND_SURV};
          end else if (k_low) begin
            res_d = '{person: '0, kind: jos_pkg::KIND_ERR};
          end else begin
            mod_start_o = 1'b1;
            cur_d       = pointer_q;
          end
        end
      end
      jos_pkg::ST_FILL: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = fill_q;
        mem_wdata_o = (CW'(fill_q) < people_i);
        fill_d      = fill_q + 1'b1;
      end
      jos_pkg::ST_MOD: begin
        if (mod_done_i) begin
          adv_d  = mod_rem_i;
          hits_d = '0;
          scan_d = ring_next(pointer_q);
          // zero advance: the person at the pointer goes out
          if (mod_rem_i == '0) begin
            mem_we_o    = 1'b1;
            mem_waddr_o = pointer_q;
          end
        end
      end
      jos_pkg::ST_SCAN: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = scan_q;
        scan_d      = ring_next(scan_q);
        slot_d      = scan_q;
        rd_vld_d    = 1'b1;
        if (hit) begin
          hits_d = hit_n;
          if (hit_n == adv_q) begin
            cur_d       = slot_q;
            mem_we_o    = 1'b1;
            mem_waddr_o = slot_q;
          end
          if (hit_n == adv_inc) begin
            pointer_d   = slot_q;
            remaining_d = remaining_q - One;
            rd_vld_d    = 1'b0;
            res_d       = '{person: to_person(cur_q), kind: jos_pkg::KIND_ELIM};
          end
        end
      end
      jos_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= jos_pkg::ST_IDLE;
      active_q    <= 1'b0;
      remaining_q <= '0;
      pointer_q   <= '0;
      rd_vld_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      remaining_q <= remaining_d;
      pointer_q   <= pointer_d;
      rd_vld_q    <= rd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fill_q <= fill_d;
    adv_q  <= adv_d;
    hits_q <= hits_d;
    cur_q  <= cur_d;
    scan_q <= scan_d;
    slot_q <= slot_d;
    res_q  <= res_d;
  end

  assign in_stall_o     = (state_q != jos_pkg::ST_IDLE);
  assign res_valid_o    = (state_q == jos_pkg::ST_DONE);
  assign res_o          = res_q;
  assign mod_dividend_o = step_i - One;
  assign mod_divisor_o  = remaining_q;

endmodule
